>>> rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and codes shared by the command frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  // Byte class tags
  typedef enum logic [2:0] {
    KIND_ID_LO   = 3'd0,
    KIND_ID_HI   = 3'd1,
    KIND_OP_LEN  = 3'd2,
    KIND_OP      = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_DISCARD = 3'd5
  } kind_t;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_BADLEN = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_OVER   = 3'd4
  } status_t;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_ID_LO   = 6'b000001,
    PH_ID_HI   = 6'b000010,
    PH_OPLEN   = 6'b000100,
    PH_OP      = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DISCARD = 6'b100000
  } phase_t;

  localparam int unsigned PLEN_W = 10;
  localparam int unsigned PLEN_CAP = 1023;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    kind_t             byte_kind;
    logic              frame_end;
    status_t           frame_status;
    logic [15:0]       frame_id;
    logic [7:0]        op_length;
    logic [PLEN_W-1:0] payload_length;
  } out_item_t;

endpackage : cfd_pkg

`default_nettype wire

>>> rtl/command_frame_deframer.sv
// ----------------------------------------------------------------------------
// command_frame_deframer
// Byte-wise command frame parser with per-byte class tags and frame summary.
// ----------------------------------------------------------------------------
// Accepts one frame byte per clock while not stalled and returns one result
// per byte: the input register feeds the phase logic, whose output loads
// the result register. Throughput is one byte per cycle when unstalled, set by
// the combinational phase update and length compare between
// those two registers; the input stalls only while both registers hold data
// and the consumer stalls. Frame id, op length, payload length and status are
// reported on the result carrying frame_end and read zero on other results.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_deframer
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_OP_LEN  = 15,
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire in_item_t item,
  output logic          result_valid,
  input  wire logic     result_stall,
  output out_item_t     result
);

  localparam int unsigned BOUND_INT = (MAX_PAYLOAD > PLEN_CAP) ? PLEN_CAP : MAX_PAYLOAD;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_busy;
  logic      fire;
  out_item_t parsed;

  cfd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (item_valid),
    .up_stall (item_stall),
    .up_item  (item),
    .hold     (out_busy),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  // A held byte moves on whenever the result register can take it
  assign fire = s1_valid && !out_busy;

  cfd_parser #(
    .MAX_OP_LEN  (MAX_OP_LEN),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (parsed)
  );

  cfd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_valid),
    .load_item (parsed),
    .busy      (out_busy),
    .valid     (result_valid),
    .stall     (result_stall),
    .item      (result)
  );

  // Input stalls only when the input register is full and blocked
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("input stalled without a blocked pipeline");

  // Summary fields stay clear away from the frame end
  a_summary_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.frame_end) |->
      (result.frame_status == ST_OK && result.frame_id == 16'h0000 &&
       result.op_length == 8'h00 && result.payload_length == '0))
    else $error("frame summary outside frame end");

  // Short header reports no id or lengths
  a_short_header: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_end && result.frame_status == ST_SHORT) |->
      (result.frame_id == 16'h0000 && result.payload_length == '0))
    else $error("short header carries id or length");

  // Payload count never exceeds its bound
  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.payload_length <= PLEN_W'(BOUND_INT)))
    else $error("payload length above bound");

endmodule : command_frame_deframer

`default_nettype wire

>>> rtl/cfd_in_stage.sv
// ----------------------------------------------------------------------------
// cfd_in_stage
// Input register: captures one byte transaction and holds it while the
// result register downstream is blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_in_stage
  import cfd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     up_valid,
  output logic          up_stall,
  input  wire in_item_t up_item,
  input  wire logic     hold,
  output logic          valid,
  output in_item_t      item
);

  // Block the upstream side only while a captured byte cannot move on
  assign up_stall = valid && hold;

  // Advance the valid flag whenever the held byte is free to leave
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  // Capture payload on an accepted transaction
  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      item <= up_item;
    end
  end

endmodule : cfd_in_stage

`default_nettype wire

>>> rtl/cfd_parser.sv
// ----------------------------------------------------------------------------
// cfd_parser
// Frame parse state and the single-pass classification of one byte,
// including the frame summary reported on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_parser
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_OP_LEN  = 15,
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  output out_item_t     result
);

  localparam int unsigned OPW = $clog2(MAX_OP_LEN + 1);
  localparam int unsigned BOUND_INT = (MAX_PAYLOAD > PLEN_CAP) ? PLEN_CAP : MAX_PAYLOAD;
  localparam logic [PLEN_W-1:0] PAYLOAD_BOUND = PLEN_W'(BOUND_INT);
  localparam logic [7:0] OP_LEN_MAX = 8'(MAX_OP_LEN);

  phase_t            phase, phase_next;
  logic [15:0]       id_reg, id_next;
  logic [7:0]        olen_reg, olen_next;
  logic [OPW-1:0]    left_reg, left_next, left_dec;
  logic [PLEN_W-1:0] count_reg, count_next;
  status_t           err_reg, err_next;
  kind_t             kind;
  logic [7:0]        b;
  logic              last;

  assign b    = item.in_byte;
  assign last = item.last_byte;
  assign left_dec = (left_reg != '0) ? left_reg - OPW'(1) : left_reg;

  // Classify the byte and work out the next parse state
  always_comb begin
    phase_next = phase;
    id_next    = id_reg;
    olen_next  = olen_reg;
    left_next  = left_reg;
    count_next = count_reg;
    err_next   = err_reg;
    kind       = KIND_DISCARD;
    unique case (phase)
      PH_ID_LO: begin
        kind       = KIND_ID_LO;
        id_next    = {8'h00, b};
        phase_next = PH_ID_HI;
        if (last) err_next = ST_SHORT;
      end
      PH_ID_HI: begin
        kind       = KIND_ID_HI;
        id_next    = {b, id_reg[7:0]};
        phase_next = PH_OPLEN;
        if (last) err_next = ST_SHORT;
      end
      PH_OPLEN: begin
        kind      = KIND_OP_LEN;
        olen_next = b;
        if (b == 8'h00 || b > OP_LEN_MAX) begin
          err_next   = ST_BADLEN;
          phase_next = PH_DISCARD;
        end else begin
          left_next  = b[OPW-1:0];
          phase_next = PH_OP;
          if (last) err_next = ST_TRUNC;
        end
      end
      PH_OP: begin
        kind      = KIND_OP;
        left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_PAYLOAD;
        end else if (last) begin
          err_next = ST_TRUNC;
        end
      end
      PH_PAYLOAD: begin
        if (count_reg >= PAYLOAD_BOUND) begin
          kind       = KIND_DISCARD;
          count_next = PAYLOAD_BOUND;
          err_next   = ST_OVER;
          phase_next = PH_DISCARD;
        end else begin
          kind       = KIND_PAYLOAD;
          count_next = count_reg + PLEN_W'(1);
        end
      end
      PH_DISCARD: begin
        kind = KIND_DISCARD;
      end
      default: begin
        kind = KIND_DISCARD;
      end
    endcase
  end

  // Build the result; the frame summary is shown on the final byte only
  always_comb begin
    result                = '0;
    result.out_byte       = b;
    result.byte_kind      = kind;
    result.frame_end      = last;
    result.frame_status   = ST_OK;
    if (last) begin
      result.frame_status = err_next;
      if (err_next != ST_SHORT) begin
        result.frame_id  = id_next;
        result.op_length = olen_next;
      end
      if (err_next == ST_OK || err_next == ST_OVER) begin
        result.payload_length = count_next;
      end
    end
  end

  // Update parse state per transaction; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst || (fire && last)) begin
      phase     <= PH_ID_LO;
      id_reg    <= '0;
      olen_reg  <= '0;
      left_reg  <= '0;
      count_reg <= '0;
      err_reg   <= ST_OK;
    end else if (fire) begin
      phase     <= phase_next;
      id_reg    <= id_next;
      olen_reg  <= olen_next;
      left_reg  <= left_next;
      count_reg <= count_next;
      err_reg   <= err_next;
    end
  end

endmodule : cfd_parser

`default_nettype wire

>>> rtl/cfd_out_stage.sv
// ----------------------------------------------------------------------------
// cfd_out_stage
// Result register: holds one classified byte until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_out_stage
  import cfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t load_item,
  output logic           busy,
  output logic           valid,
  input  wire logic      stall,
  output out_item_t      item
);

  // Full and blocked: nothing new may enter this cycle
  assign busy = valid && stall;

  // Refill or drain whenever the consumer is not stalling a held result
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!busy) begin
      valid <= load;
    end
  end

  // Capture a new result
  always_ff @(posedge clk) begin
    if (load && !busy) begin
      item <= load_item;
    end
  end

endmodule : cfd_out_stage

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command frame deframer. Sends short directed
// frames for each status but oversize, then random frames (mostly well formed,
// some broken, one at and one over the payload bound). A scoreboard predicts
// every tagged byte and frame summary, compares results in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import cfd_pkg::*;

  localparam int unsigned MAX_OP_LEN  = 15;
  localparam int unsigned MAX_PAYLOAD = 512;
  localparam int unsigned PAY_BOUND   = (MAX_PAYLOAD > PLEN_CAP) ? PLEN_CAP : MAX_PAYLOAD;
  localparam int unsigned BYTE_BUDGET = 1550;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item;
  logic      result_valid;
  logic      result_stall;
  out_item_t result;

  // Byte predictor and in-order result checker
  class frame_scoreboard;
    phase_t          phase;
    logic [15:0]     id_acc;
    logic [7:0]      oplen_acc;
    logic [3:0]      ops_left;
    logic [9:0]      pay_count;
    status_t         err;
    out_item_t       expected_q[$];
    int unsigned     mismatches;
    int unsigned     bytes_seen;
    int unsigned     status_hits[5];

    function new();
      mismatches = 0;
      bytes_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase     = PH_ID_LO;
      id_acc    = '0;
      oplen_acc = '0;
      ops_left  = '0;
      pay_count = '0;
      err       = ST_OK;
    endfunction

    // Advance the parse state for one accepted byte and queue its result
    function void note_byte(in_item_t it);
      out_item_t exp;
      exp = '0;
      exp.out_byte     = it.in_byte;
      exp.frame_end    = it.last_byte;
      exp.frame_status = ST_OK;
      case (phase)
        PH_ID_LO: begin
          exp.byte_kind = KIND_ID_LO;
          id_acc = {8'h00, it.in_byte};
          phase  = PH_ID_HI;
          if (it.last_byte) err = ST_SHORT;
        end
        PH_ID_HI: begin
          exp.byte_kind = KIND_ID_HI;
          id_acc[15:8] = it.in_byte;
          phase = PH_OPLEN;
          if (it.last_byte) err = ST_SHORT;
        end
        PH_OPLEN: begin
          exp.byte_kind = KIND_OP_LEN;
          oplen_acc = it.in_byte;
          if (it.in_byte == 8'd0 || it.in_byte > MAX_OP_LEN) begin
            err   = ST_BADLEN;
            phase = PH_DISCARD;
          end else begin
            ops_left = it.in_byte[3:0];
            phase    = PH_OP;
            if (it.last_byte) err = ST_TRUNC;
          end
        end
        PH_OP: begin
          exp.byte_kind = KIND_OP;
          if (ops_left > 0) ops_left = ops_left - 4'd1;
          if (ops_left == 0) phase = PH_PAYLOAD;
          else if (it.last_byte) err = ST_TRUNC;
        end
        PH_PAYLOAD: begin
          if (pay_count >= PAY_BOUND) begin
            // count saturated: flag oversize and drop the rest
            exp.byte_kind = KIND_DISCARD;
            pay_count = PAY_BOUND[9:0];
            err   = ST_OVER;
            phase = PH_DISCARD;
          end else begin
            exp.byte_kind = KIND_PAYLOAD;
            pay_count = pay_count + 10'd1;
          end
        end
        default: exp.byte_kind = KIND_DISCARD;
      endcase

      // Close the frame: report the summary and return to idle state
      if (it.last_byte) begin
        exp.frame_status = err;
        if (err != ST_SHORT) begin
          exp.frame_id  = id_acc;
          exp.op_length = oplen_acc;
          if (err == ST_OK || err == ST_OVER) exp.payload_length = pay_count;
        end
        status_hits[int'(err)]++;
        clear_frame();
      end
      bytes_seen++;
      expected_q.push_back(exp);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: out_byte %0d", got.out_byte);
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("out_byte", exp.out_byte, got.out_byte);
      compare_field("byte_kind", exp.byte_kind, got.byte_kind);
      compare_field("frame_end", exp.frame_end, got.frame_end);
      compare_field("frame_status", exp.frame_status, got.frame_status);
      compare_field("frame_id", exp.frame_id, got.frame_id);
      compare_field("op_length", exp.op_length, got.op_length);
      compare_field("payload_length", exp.payload_length, got.payload_length);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  frame_scoreboard sb;
  logic [7:0]      frame_q[$];
  bit              quiet;
  int unsigned     frame_no;

  command_frame_deframer #(
    .MAX_OP_LEN  (MAX_OP_LEN),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side in random bursts
  initial begin
    result_stall <= 1'b0;
    forever begin
      int unsigned n;
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Send one byte; called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    in_item_t    it;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.in_byte   = b;
    it.last_byte = lst;
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_byte(it);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_header(input logic [7:0] oplen);
    push_random(2);
    frame_q.push_back(oplen);
  endtask

  task automatic push_good(input int unsigned oplen, input int unsigned paylen);
    push_header(8'(oplen));
    push_random(oplen + paylen);
  endtask

  initial begin
    sb         = new();
    quiet      = 1'b0;
    frame_no   = 0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: each status case but oversize, and the field extremes
    push_random(1);
    send_frame();                       // ends on id low byte
    frame_q = '{8'hFF, 8'hFF};
    send_frame();                       // ends on id high byte
    frame_q = '{8'h00, 8'h00, 8'h00};
    send_frame();                       // zero op length, closes on it
    push_header(8'd16);
    push_random(2);
    send_frame();                       // op length just over the limit
    push_header(8'hFF);
    send_frame();                       // largest op length byte
    push_header(8'd3);
    send_frame();                       // truncated on the op length byte
    push_header(8'(MAX_OP_LEN));
    push_random(2);
    send_frame();                       // truncated inside the op bytes
    push_good(1, 0);
    send_frame();                       // well formed, no payload

    // Random frames, mostly well formed
    while (sb.bytes_seen < BYTE_BUDGET) begin
      int unsigned r;
      int unsigned oplen;
      frame_no++;
      quiet = ($urandom_range(0, 7) == 0);
      r     = $urandom_range(0, 99);
      oplen = $urandom_range(1, MAX_OP_LEN);
      if (frame_no == 6) begin
        push_good(oplen, PAY_BOUND);    // payload exactly at the bound
      end else if (frame_no == 30) begin
        push_good(oplen, $urandom_range(PAY_BOUND + 1, PAY_BOUND + 8));
      end else if (r < 75) begin
        push_good(oplen, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24));
      end else if (r < 83) begin
        push_random($urandom_range(1, 2));
      end else if (r < 91) begin
        push_header(($urandom_range(0, 3) == 0) ? 8'd0 :
                    8'($urandom_range(MAX_OP_LEN + 1, 255)));
        push_random($urandom_range(0, 6));
      end else begin
        push_header(8'(oplen));
        push_random($urandom_range(0, oplen - 1));
      end
      send_frame();
    end
    item_valid <= 1'b0;

    // Drain the pipeline
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d random frames plus directed frames.",
             sb.bytes_seen, frame_no);
    $display("Frame status counts: ok %0d, short %0d, bad op length %0d, %s",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             $sformatf("truncated %0d, oversize %0d",
                       sb.status_hits[3], sb.status_hits[4]));
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
